// ===== rtl/gwsm_pkg.sv =====
// Shared types and constants for the grid word search marker.
package gwsm_pkg;

  localparam int OP_W     = 3;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 5;
  localparam int LETTER_W = 8;
  localparam int WIDX_W   = 5;
  localparam int WLEN_W   = 6;
  localparam int COUNT_W  = 14;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;
  localparam logic [CFG_W-1:0] ROWS_RESET = 6'd32;
  localparam logic [CFG_W-1:0] COLS_RESET = 6'd32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_GRID = 3'd0,
    OP_LOAD_WORD = 3'd1,
    OP_SEARCH    = 3'd2,
    OP_READ      = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_NOP       = 3'd7
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                cell_ok;
    logic                word_ok;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [LETTER_W-1:0] letter;
    logic [WIDX_W-1:0]   word_index;
    logic [WLEN_W-1:0]   word_length;
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_ISSUE,
    B_CMP,
    B_MARK,
    B_DONE
  } bstate_t;

  localparam logic signed [1:0] DIR_DX [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                              2'sd0, -2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] DIR_DY [8] = '{2'sd1, -2'sd1, 2'sd1, 2'sd0,
                                              -2'sd1, 2'sd0, -2'sd1, 2'sd1};

endpackage

// ===== rtl/gwsm_ifs.sv =====
// Request and result channel interfaces.
interface gwsm_in_if;
  import gwsm_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [LETTER_W-1:0] letter;
  logic [WIDX_W-1:0]   word_index;
  logic [WLEN_W-1:0]   word_length;
  modport source (output valid, operation, row, col, letter, word_index, word_length,
                  input ready);
  modport sink (input valid, operation, row, col, letter, word_index, word_length,
                output ready);
endinterface

interface gwsm_out_if;
  import gwsm_pkg::*;
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] cell_letter;
  logic                cell_marked;
  logic [COUNT_W-1:0]  match_count;
  modport source (output valid, cell_letter, cell_marked, match_count, input ready);
  modport sink (input valid, cell_letter, cell_marked, match_count, output ready);
endinterface

// ===== rtl/grid_word_search_marker.sv =====
// Top level of the grid word search marker.
// One request in, one result out. Loads and unknown operations are answered
// straight from the idle state, a read of a cell in the area via the read state.
// A clear walks the mark memory one cell per cycle and then reports; the same
// pass runs after reset, during which no request is taken. A search walks every
// start cell and the eight directions through one grid memory read port:
// each letter compared passes an issue state and a compare state, a candidate
// that runs out of the area is dropped in the issue state, each match is
// marked letter by letter in the mark state, and the count is reported last.
// A two-entry queue lets requests arrive while the execution unit is busy.
module grid_word_search_marker #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32,
  parameter int MAX_WORD = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gwsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gwsm_pkg::CFG_W-1:0]     cfg_wdata,
  gwsm_in_if.sink                        in_ch,
  gwsm_out_if.source                     out_ch
);
  import gwsm_pkg::*;

  logic q_valid, q_pop, init_busy;
  cmd_t q_data;

  gwsm_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .MAX_WORD(MAX_WORD)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .hold    (init_busy),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  gwsm_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .MAX_WORD(MAX_WORD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/gwsm_front.sv =====
// Request intake, classification and two-entry command queue.
module gwsm_front #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32,
  parameter int MAX_WORD = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  gwsm_in_if.sink         in_ch,
  input  logic            hold,
  output logic            q_valid,
  output gwsm_pkg::cmd_t  q_data,
  input  logic            q_pop
);
  import gwsm_pkg::*;

  cmd_t       entry_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd;

  assign in_ch.ready = (cnt_r != 2'd2) && !hold;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = entry_r[rptr_r];

  always_comb begin
    case (in_ch.operation)
      OP_LOAD_GRID: cmd.op = OP_LOAD_GRID;
      OP_LOAD_WORD: cmd.op = OP_LOAD_WORD;
      OP_SEARCH:    cmd.op = OP_SEARCH;
      OP_READ:      cmd.op = OP_READ;
      OP_CLEAR:     cmd.op = OP_CLEAR;
      default:      cmd.op = OP_NOP;
    endcase
    cmd.cell_ok     = (32'(in_ch.row) < MAX_ROWS) && (32'(in_ch.col) < MAX_COLS);
    cmd.word_ok     = 32'(in_ch.word_index) < MAX_WORD;
    cmd.row         = in_ch.row;
    cmd.col         = in_ch.col;
    cmd.letter      = in_ch.letter;
    cmd.word_index  = in_ch.word_index;
    cmd.word_length = in_ch.word_length;
  end

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = q_pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/gwsm_back.sv =====
// Command execution: grid and mark memories, word store, search sequencer.
module gwsm_back #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32,
  parameter int MAX_WORD = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gwsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gwsm_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               q_valid,
  input  gwsm_pkg::cmd_t                     q_data,
  output logic                               q_pop,
  output logic                               init_busy,
  gwsm_out_if.source                         out_ch
);
  import gwsm_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RCW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int PRW   = NRW + 1;
  localparam int PCW   = NCW + 1;
  localparam int WIW   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int LW    = $clog2(MAX_WORD + 1);

  logic [LETTER_W-1:0] grid_mem [CELLS];
  logic                mark_mem [CELLS];
  logic [LETTER_W-1:0] word_mem [MAX_WORD];
  logic [LETTER_W-1:0] grid_q;
  logic                mark_q;

  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  bstate_t          state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             clr_emit_r, clr_emit_nxt;
  logic [RCW-1:0]   r_r, r_nxt;
  logic [CCW-1:0]   c_r, c_nxt;
  logic [2:0]       d_r, d_nxt;
  logic [WIW-1:0]   i_r, i_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic signed [PRW-1:0] py_r, py_nxt;
  logic signed [PCW-1:0] px_r, px_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]         rd_cell_r, rd_cell_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [LETTER_W-1:0] out_letter_r, out_letter_nxt;
  logic                out_marked_r, out_marked_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [NRW-1:0] rows_lim;
  logic [NCW-1:0] cols_lim;
  logic [LW-1:0]  len_lim;
  logic [AW-1:0]  head_cell, pos_addr, grid_raddr, mark_raddr, mark_waddr;
  logic           grid_we, word_we, mark_we, can_emit, in_bounds;
  logic           last_d, last_c, last_r, last_i;
  logic [RCW-1:0] adv_r;
  logic [CCW-1:0] adv_c;
  logic           adv_done;

  assign rows_lim = NRW'((32'(rows_cfg_r) > MAX_ROWS) ? MAX_ROWS : 32'(rows_cfg_r));
  assign cols_lim = NCW'((32'(cols_cfg_r) > MAX_COLS) ? MAX_COLS : 32'(cols_cfg_r));
  assign len_lim  = LW'((32'(q_data.word_length) > MAX_WORD) ? MAX_WORD
                        : 32'(q_data.word_length));
  assign head_cell = AW'(32'(q_data.row) * MAX_COLS + 32'(q_data.col));
  assign pos_addr  = AW'(32'($unsigned(py_r)) * MAX_COLS + 32'($unsigned(px_r)));
  assign in_bounds = (py_r >= 0) && (px_r >= 0)
                  && (32'($unsigned(py_r)) < 32'(rows_lim))
                  && (32'($unsigned(px_r)) < 32'(cols_lim));
  assign can_emit  = !out_valid_r || out_ch.ready;
  assign init_busy = (state_r == B_CLEAR) && !clr_emit_r;

  assign last_d = (d_r == 3'd7);
  assign last_c = (32'(c_r) == 32'(cols_lim) - 32'd1);
  assign last_r = (32'(r_r) == 32'(rows_lim) - 32'd1);
  assign last_i = (32'(i_r) == 32'(len_r) - 32'd1);

  always_comb begin
    adv_r    = r_r;
    adv_c    = c_r;
    adv_done = 1'b0;
    if (last_d) begin
      if (last_c) begin
        adv_c = '0;
        if (last_r) begin
          adv_done = 1'b1;
        end else begin
          adv_r = r_r + 1'b1;
        end
      end else begin
        adv_c = c_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_emit_nxt   = clr_emit_r;
    r_nxt          = r_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    i_nxt          = i_r;
    len_nxt        = len_r;
    py_nxt         = py_r;
    px_nxt         = px_r;
    cnt_nxt        = cnt_r;
    rd_cell_nxt    = rd_cell_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_letter_nxt = out_letter_r;
    out_marked_nxt = out_marked_r;
    out_count_nxt  = out_count_r;
    q_pop          = 1'b0;
    grid_we        = 1'b0;
    word_we        = 1'b0;
    mark_we        = 1'b0;
    mark_waddr     = pos_addr;
    grid_raddr     = pos_addr;
    mark_raddr     = rd_cell_r;
    case (state_r)
      B_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == CELLS - 1) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_emit_r ? B_DONE : B_IDLE;
        end
      end
      B_IDLE: begin
        grid_raddr  = head_cell;
        mark_raddr  = head_cell;
        rd_cell_nxt = head_cell;
        if (q_valid && can_emit) begin
          q_pop          = 1'b1;
          out_letter_nxt = '0;
          out_marked_nxt = 1'b0;
          out_count_nxt  = '0;
          case (q_data.op)
            OP_LOAD_GRID: begin
              grid_we       = q_data.cell_ok;
              out_valid_nxt = 1'b1;
            end
            OP_LOAD_WORD: begin
              word_we       = q_data.word_ok;
              out_valid_nxt = 1'b1;
            end
            OP_READ: begin
              if (q_data.cell_ok) begin
                state_nxt = B_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_nxt      = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = B_CLEAR;
            end
            OP_SEARCH: begin
              if (len_lim == '0 || rows_lim == '0 || cols_lim == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                r_nxt     = '0;
                c_nxt     = '0;
                d_nxt     = '0;
                i_nxt     = '0;
                py_nxt    = '0;
                px_nxt    = '0;
                len_nxt   = len_lim;
                cnt_nxt   = '0;
                state_nxt = B_ISSUE;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      B_READ: begin
        grid_raddr = rd_cell_r;
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_letter_nxt = grid_q;
          out_marked_nxt = mark_q;
          out_count_nxt  = '0;
          state_nxt      = B_IDLE;
        end
      end
      B_ISSUE: begin
        if (in_bounds) begin
          state_nxt = B_CMP;
        end else begin
          r_nxt     = adv_r;
          c_nxt     = adv_c;
          d_nxt     = d_r + 1'b1;
          i_nxt     = '0;
          py_nxt    = PRW'(adv_r);
          px_nxt    = PCW'(adv_c);
          state_nxt = adv_done ? B_DONE : B_ISSUE;
        end
      end
      B_CMP: begin
        if (grid_q != word_mem[i_r]) begin
          r_nxt     = adv_r;
          c_nxt     = adv_c;
          d_nxt     = d_r + 1'b1;
          i_nxt     = '0;
          py_nxt    = PRW'(adv_r);
          px_nxt    = PCW'(adv_c);
          state_nxt = adv_done ? B_DONE : B_ISSUE;
        end else if (last_i) begin
          cnt_nxt   = cnt_r + 1'b1;
          i_nxt     = '0;
          py_nxt    = PRW'(r_r);
          px_nxt    = PCW'(c_r);
          state_nxt = B_MARK;
        end else begin
          i_nxt     = i_r + 1'b1;
          py_nxt    = py_r + PRW'(DIR_DY[d_r]);
          px_nxt    = px_r + PCW'(DIR_DX[d_r]);
          state_nxt = B_ISSUE;
        end
      end
      B_MARK: begin
        mark_we = 1'b1;
        if (last_i) begin
          r_nxt     = adv_r;
          c_nxt     = adv_c;
          d_nxt     = d_r + 1'b1;
          i_nxt     = '0;
          py_nxt    = PRW'(adv_r);
          px_nxt    = PCW'(adv_c);
          state_nxt = adv_done ? B_DONE : B_ISSUE;
        end else begin
          i_nxt  = i_r + 1'b1;
          py_nxt = py_r + PRW'(DIR_DY[d_r]);
          px_nxt = px_r + PCW'(DIR_DX[d_r]);
        end
      end
      B_DONE: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_letter_nxt = '0;
          out_marked_nxt = 1'b0;
          out_count_nxt  = cnt_r;
          clr_emit_nxt   = 1'b0;
          state_nxt      = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[head_cell] <= q_data.letter;
    end
    grid_q <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= (state_r == B_MARK);
    end
    mark_q <= mark_mem[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[WIW'(q_data.word_index)] <= q_data.letter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rows_cfg_r  <= ROWS_RESET;
      cols_cfg_r  <= COLS_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_ROWS) begin
        rows_cfg_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_COLS) begin
        cols_cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r          <= r_nxt;
    c_r          <= c_nxt;
    d_r          <= d_nxt;
    i_r          <= i_nxt;
    len_r        <= len_nxt;
    py_r         <= py_nxt;
    px_r         <= px_nxt;
    cnt_r        <= cnt_nxt;
    rd_cell_r    <= rd_cell_nxt;
    out_letter_r <= out_letter_nxt;
    out_marked_r <= out_marked_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cell_letter = out_letter_r;
  assign out_ch.cell_marked = out_marked_r;
  assign out_ch.match_count = out_count_r;

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && state_r == B_IDLE && can_emit))
    else $error("command taken outside idle or with result slot busy");

  a_cmp_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CMP) |-> ($past(state_r) == B_ISSUE))
    else $error("letter compare without a grid read");

  a_mark_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MARK) |-> in_bounds)
    else $error("mark written outside the area in use");

endmodule

// ===== sim/tb_grid_word_search_marker.sv =====
// Self-checking testbench for the grid word search marker with its own predictor.
module tb_grid_word_search_marker;
  timeunit 1ns;
  timeprecision 1ps;
  import gwsm_pkg::*;

  typedef struct {
    op_t                 op;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [LETTER_W-1:0] letter;
    logic [WIDX_W-1:0]   widx;
    logic [WLEN_W-1:0]   wlen;
  } request_t;

  typedef struct {
    logic [LETTER_W-1:0] letter;
    logic                marked;
    logic [COUNT_W-1:0]  count;
  } answer_t;

  typedef struct {
    request_t req;
    bit       typed;
    answer_t  ans;
  } directed_row_t;

  localparam int NCELL = 1024;
  localparam int IDLE_LIMIT = 200000;
  localparam int dx_tab[8] = '{1, -1, 0, 1, 0, -1, 1, -1};
  localparam int dy_tab[8] = '{1, -1, 1, 0, -1, 0, -1, 1};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  gwsm_in_if  in_ch();
  gwsm_out_if out_ch();

  grid_word_search_marker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [LETTER_W-1:0] grid_mem [NCELL];
  logic [LETTER_W-1:0] word_mem [32];
  bit                  mark_mem [NCELL];
  logic [CFG_W-1:0]    rows_cfg;
  logic [CFG_W-1:0]    cols_cfg;

  answer_t pending_answers [$];
  int fail_cnt;
  int results_seen;
  int idle_cycles;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [COUNT_W-1:0] count_matches(logic [WLEN_W-1:0] wlen);
    int rows, cols, len, y, x;
    bit ok;
    logic [COUNT_W-1:0] n;
    rows = rows_cfg > 32 ? 32 : rows_cfg;
    cols = cols_cfg > 32 ? 32 : cols_cfg;
    len = wlen > 32 ? 32 : wlen;
    n = '0;
    if (len == 0) return n;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        for (int d = 0; d < 8; d++) begin
          ok = 1;
          for (int i = 0; i < len && ok; i++) begin
            y = r + i * dy_tab[d];
            x = c + i * dx_tab[d];
            if (y < 0 || y >= rows || x < 0 || x >= cols || grid_mem[y*32+x] != word_mem[i])
              ok = 0;
          end
          if (ok) begin
            n++;
            for (int i = 0; i < len; i++)
              mark_mem[(r + i*dy_tab[d])*32 + c + i*dx_tab[d]] = 1;
          end
        end
    return n;
  endfunction

  function automatic answer_t apply_request(request_t q);
    answer_t a;
    a = '{default: '0};
    case (q.op)
      OP_LOAD_GRID: grid_mem[q.row*32 + q.col] = q.letter;
      OP_LOAD_WORD: word_mem[q.widx] = q.letter;
      OP_SEARCH:    a.count = count_matches(q.wlen);
      OP_READ: begin
        a.letter = grid_mem[q.row*32 + q.col];
        a.marked = mark_mem[q.row*32 + q.col];
      end
      OP_CLEAR: foreach (mark_mem[i]) mark_mem[i] = 0;
      default: ;
    endcase
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [LETTER_W-1:0] pick_letter();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'hFF;
    if (r == 1) return 8'h00;
    if (r == 2) return LETTER_W'($urandom_range(0, 255));
    return LETTER_W'(8'h41 + $urandom_range(0, 2));
  endfunction

  function automatic request_t random_fields();
    request_t q;
    q.op = OP_NOP;
    q.row = ROW_W'($urandom_range(0, 31));
    q.col = COL_W'($urandom_range(0, 31));
    q.letter = LETTER_W'($urandom_range(0, 255));
    q.widx = WIDX_W'($urandom_range(0, 31));
    q.wlen = WLEN_W'($urandom_range(0, 63));
    return q;
  endfunction

  task automatic send_request(request_t q, bit typed = 0, answer_t want = '{default: '0});
    int g;
    answer_t a;
    g = pick_gap();
    @(negedge clk);
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.operation = q.op;
    in_ch.row = q.row;
    in_ch.col = q.col;
    in_ch.letter = q.letter;
    in_ch.word_index = q.widx;
    in_ch.word_length = q.wlen;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    a = apply_request(q);
    if (typed) begin
      if (a.letter !== want.letter) begin
        $error("cell_letter: expected %0h, actual %0h", want.letter, a.letter);
        fail_cnt++;
      end
      if (a.marked !== want.marked) begin
        $error("cell_marked: expected %0d, actual %0d", want.marked, a.marked);
        fail_cnt++;
      end
      if (a.count !== want.count) begin
        $error("match_count: expected %0d, actual %0d", want.count, a.count);
        fail_cnt++;
      end
    end
    pending_answers.insert(pending_answers.size(), a);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_ROWS) rows_cfg = val;
    else cols_cfg = val;
  endtask

  task automatic planted_search(int rows, int cols);
    request_t q;
    int d, len, r, c;
    d = $urandom_range(0, 7);
    len = $urandom_range(1, 5);
    r = $urandom_range(0, rows - 1);
    c = $urandom_range(0, cols - 1);
    q = random_fields();
    if (r + (len-1)*dy_tab[d] >= 0 && r + (len-1)*dy_tab[d] < rows &&
        c + (len-1)*dx_tab[d] >= 0 && c + (len-1)*dx_tab[d] < cols) begin
      for (int i = 0; i < len; i++) begin
        q = random_fields();
        q.op = OP_LOAD_WORD;
        q.widx = WIDX_W'(i);
        q.letter = grid_mem[(r + i*dy_tab[d])*32 + c + i*dx_tab[d]];
        send_request(q);
      end
    end else begin
      len = 1;
    end
    q = random_fields();
    q.op = OP_SEARCH;
    q.wlen = WLEN_W'(len);
    send_request(q);
  endtask

  task automatic random_phase(int items);
    request_t q;
    int rows, cols, k;
    rows = rows_cfg > 32 ? 32 : (rows_cfg == 0 ? 1 : rows_cfg);
    cols = cols_cfg > 32 ? 32 : (cols_cfg == 0 ? 1 : cols_cfg);
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      q = random_fields();
      k = $urandom_range(0, 99);
      if (k < 30) begin
        planted_search(rows, cols);
        continue;
      end else if (k < 52) begin
        q.op = OP_LOAD_GRID;
        q.letter = pick_letter();
        if (k < 48) begin
          q.row = ROW_W'($urandom_range(0, rows - 1));
          q.col = COL_W'($urandom_range(0, cols - 1));
        end
      end else if (k < 60) begin
        q.op = OP_LOAD_WORD;
        q.letter = pick_letter();
      end else if (k < 74) begin
        q.op = OP_SEARCH;
        if (k < 70) q.wlen = WLEN_W'($urandom_range(0, 4));
      end else if (k < 95) begin
        q.op = OP_READ;
      end else if (k < 96) begin
        q.op = OP_CLEAR;
      end else begin
        q.op = op_t'($urandom_range(OP_CLEAR + 1, OP_NOP));
      end
      send_request(q);
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (results_seen >= 500 && results_seen < 510) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        results_seen = 510;
      end else if (pick_gap() > 0) begin
        out_ch.ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt++;
      end else begin
        answer_t e;
        e = pending_answers.pop_front();
        if (out_ch.cell_letter !== e.letter) begin
          $error("cell_letter: expected %0h, actual %0h", e.letter, out_ch.cell_letter);
          fail_cnt++;
        end
        if (out_ch.cell_marked !== e.marked) begin
          $error("cell_marked: expected %0d, actual %0d", e.marked, out_ch.cell_marked);
          fail_cnt++;
        end
        if (out_ch.match_count !== e.count) begin
          $error("match_count: expected %0d, actual %0d", e.count, out_ch.match_count);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    directed_row_t dir_rows [$];
    request_t q;
    int settings [10][2];
    fail_cnt = 0;
    results_seen = 0;
    idle_cycles = 0;
    quiet = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ROWS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_NOP;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.letter = '0;
    in_ch.word_index = '0;
    in_ch.word_length = '0;
    rows_cfg = ROWS_RESET;
    cols_cfg = COLS_RESET;
    foreach (mark_mem[i]) mark_mem[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    quiet = 1;
    for (int i = 0; i < NCELL; i++) begin
      q = random_fields();
      q.op = OP_LOAD_GRID;
      q.row = ROW_W'(i / 32);
      q.col = COL_W'(i % 32);
      q.letter = pick_letter();
      send_request(q);
    end
    for (int i = 0; i < 32; i++) begin
      q = random_fields();
      q.op = OP_LOAD_WORD;
      q.widx = WIDX_W'(i);
      q.letter = pick_letter();
      send_request(q);
    end
    quiet = 0;

    dir_rows.insert(dir_rows.size(), '{'{OP_LOAD_GRID, 0, 0, 8'hFF, 0, 0}, 1, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_READ, 0, 0, 0, 0, 0}, 1, '{8'hFF, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_LOAD_GRID, 31, 31, 8'h00, 31, 63}, 1, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_READ, 31, 31, 8'hFF, 31, 63}, 1, '{8'h00, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_LOAD_WORD, 0, 0, 8'hFF, 0, 0}, 1, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_LOAD_WORD, 0, 0, 8'h00, 31, 0}, 1, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_SEARCH, 0, 0, 0, 0, 0}, 1, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_SEARCH, 0, 0, 0, 0, 1}, 0, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_READ, 0, 0, 0, 0, 0}, 1, '{8'hFF, 1, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_READ, 31, 31, 0, 0, 0}, 0, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_LOAD_WORD, 0, 0, 8'h41, 1, 0}, 0, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_SEARCH, 0, 0, 0, 0, 2}, 0, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_SEARCH, 0, 0, 0, 0, 32}, 0, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_SEARCH, 31, 31, 8'hFF, 31, 63}, 0, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_CLEAR, 0, 0, 0, 0, 0}, 1, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_READ, 0, 0, 0, 0, 0}, 1, '{8'hFF, 0, 0}});
    dir_rows.insert(dir_rows.size(),
                    '{'{op_t'(OP_CLEAR + 1), 0, 0, 8'hFF, 31, 63}, 1, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(),
                    '{'{op_t'(OP_CLEAR + 2), 31, 31, 8'hFF, 31, 63}, 1, '{0, 0, 0}});
    dir_rows.insert(dir_rows.size(), '{'{OP_NOP, 31, 31, 8'hFF, 31, 63}, 1, '{0, 0, 0}});
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].ans);

    settings = '{'{1, 1}, '{32, 1}, '{1, 32}, '{0, 5}, '{5, 0}, '{63, 2}, '{2, 63},
                 '{4, 4}, '{7, 3}, '{3, 8}};
    foreach (settings[p]) begin
      write_reg(REG_ROWS, CFG_W'(settings[p][0]));
      write_reg(REG_COLS, CFG_W'(settings[p][1]));
      random_phase(p == 0 ? 20 : 16);
    end
    write_reg(REG_ROWS, CFG_W'($urandom_range(1, 6)));
    write_reg(REG_COLS, CFG_W'($urandom_range(1, 6)));
    random_phase(12);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
